@@ sv/set_assoc_writeback_cache_core_assert.svh @@
// Assertion macros for the set-associative write-back cache core.
`ifndef SET_ASSOC_WRITEBACK_CACHE_CORE_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SWC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SWC_ASSERT(lbl, prop, msg)
`define SWC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/swc_pkg.sv @@
// Shared constants and types of the set-associative write-back cache.
package swc_pkg;
    localparam int SETS       = 16;
    localparam int WAYS       = 8;
    localparam int LINE_WORDS = 4;
    localparam int ADDR_BITS  = 16;
    localparam int DATA_BITS  = 8;
    localparam int AGE_BITS   = 16;

    localparam int OFF_BITS   = $clog2(LINE_WORDS);
    localparam int SET_BITS   = $clog2(SETS);
    localparam int WAY_BITS   = $clog2(WAYS);
    localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_BITS;
    localparam int LINE_ABITS = WAY_BITS + SET_BITS + OFF_BITS;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
    } t_meta;

    typedef t_meta [WAYS-1:0] t_row;

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
        logic                prior_dirty;
        logic                old_valid;
        logic [TAG_BITS-1:0] old_tag;
    } t_pick;
endpackage

@@ sv/swc_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module swc_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/swc_meta.sv @@
// Tag, state and age memory with one row per set and per-row valid bits.
module swc_meta (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_re,
    input  logic                         i_we,
    input  logic [swc_pkg::SET_BITS-1:0] i_set,
    input  swc_pkg::t_row                i_wrow,
    output swc_pkg::t_row                o_rrow
);
    import swc_pkg::*;

    t_row            r_mem [SETS];
    t_row            r_rrow;
    logic [SETS-1:0] r_row_ok;
    logic            r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_set] <= i_wrow;
        end
        if (i_re) begin
            r_rrow <= r_mem[i_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_ok[i_set] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_row_ok[i_set];
            end
        end
    end

    assign o_rrow = r_rd_ok ? r_rrow : '0;
endmodule

@@ sv/swc_lru.sv @@
// Ages a set's ways and picks the hit way or the oldest victim.
module swc_lru (
    input  swc_pkg::t_row                i_row,
    input  logic [swc_pkg::TAG_BITS-1:0] i_tag,
    output swc_pkg::t_row                o_aged,
    output swc_pkg::t_pick               o_pick
);
    import swc_pkg::*;

    t_row                aged;
    t_pick               pick;
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] old_way;
    logic [AGE_BITS-1:0] oldest;
    logic [WAY_BITS-1:0] way;

    always_comb begin
        aged = i_row;
        for (int w = 0; w < WAYS; w++) begin
            if (i_row[w].age != AGE_MAX) begin
                aged[w].age = i_row[w].age + 1'b1;
            end
        end
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w].valid && i_row[w].tag == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
        old_way = '0;
        oldest  = aged[0].age;
        for (int w = 1; w < WAYS; w++) begin
            if (aged[w].age > oldest) begin
                oldest  = aged[w].age;
                old_way = WAY_BITS'(w);
            end
        end
        way              = hit ? hit_way : old_way;
        pick.hit         = hit;
        pick.way         = way;
        pick.prior_dirty = i_row[way].dirty;
        pick.old_valid   = i_row[way].valid;
        pick.old_tag     = i_row[way].tag;
    end

    assign o_aged = aged;
    assign o_pick = pick;
endmodule

@@ sv/set_assoc_writeback_cache_core.sv @@
// Set-associative write-back, write-allocate cache with LRU replacement and a backing store.
// After reset the block clears its 65536-word backing store, one word a cycle, and takes no
// item until the clear is done. The accepting edge reads the set's tag row, the look-up state
// ages and selects the way, the access state reads or writes the line memory, and a read then
// loads the output register, which can wait for i_ready, before the next item is taken. A miss
// first writes back a dirty victim's four words, each read from the line memory and then
// written to the backing store, and then refills four words, each read from the backing store
// and then written into the line memory, since the line memory and the backing store each have
// a single port with a registered read. One item is in flight at a time.
module set_assoc_writeback_cache_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [swc_pkg::ADDR_BITS-1:0] i_address,
    input  logic [swc_pkg::DATA_BITS-1:0] i_write_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [swc_pkg::DATA_BITS-1:0] o_read_data,
    output logic                          o_hit,
    output logic                          o_was_dirty
);
    import swc_pkg::*;

    `include "set_assoc_writeback_cache_core_assert.svh"

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_WB_RD  = 4'd3;
    localparam logic [3:0] S_WB_WR  = 4'd4;
    localparam logic [3:0] S_FL_RD  = 4'd5;
    localparam logic [3:0] S_FL_WR  = 4'd6;
    localparam logic [3:0] S_ACCESS = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [ADDR_BITS-1:0] r_clr, n_clr;
    logic [OFF_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [DATA_BITS-1:0] r_wdata;
    t_pick                r_pick;
    t_row                 r_row;
    logic                 r_ovalid, n_ovalid;
    logic [DATA_BITS-1:0] r_odata;
    logic                 r_ohit;
    logic                 r_odirty;

    logic [TAG_BITS-1:0]   cur_tag;
    logic [SET_BITS-1:0]   cur_set;
    logic [OFF_BITS-1:0]   cur_off;
    logic                  accept;
    logic                  load_out;
    t_row                  meta_rrow;
    t_row                  meta_wrow;
    t_row                  aged;
    t_pick                 pick;
    logic                  line_we, line_re;
    logic [LINE_ABITS-1:0] line_addr;
    logic [DATA_BITS-1:0]  line_wdata, line_rdata;
    logic                  bs_we, bs_re;
    logic [ADDR_BITS-1:0]  bs_addr;
    logic [DATA_BITS-1:0]  bs_wdata, bs_rdata;

    assign cur_tag  = r_addr[ADDR_BITS-1 -: TAG_BITS];
    assign cur_set  = r_addr[OFF_BITS +: SET_BITS];
    assign cur_off  = r_addr[OFF_BITS-1:0];
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign load_out = (r_state == S_RESP) && (!r_ovalid || i_ready);

    swc_meta u_meta (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (accept),
        .i_we   (r_state == S_ACCESS),
        .i_set  (accept ? i_address[OFF_BITS +: SET_BITS] : cur_set),
        .i_wrow (meta_wrow),
        .o_rrow (meta_rrow)
    );

    swc_lru u_lru (
        .i_row (meta_rrow),
        .i_tag (cur_tag),
        .o_aged(aged),
        .o_pick(pick)
    );

    swc_ram #(.ADDR_W(LINE_ABITS), .DATA_W(DATA_BITS)) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (line_we),
        .i_re   (line_re),
        .i_addr (line_addr),
        .i_wdata(line_wdata),
        .o_rdata(line_rdata)
    );

    swc_ram #(.ADDR_W(ADDR_BITS), .DATA_W(DATA_BITS)) u_store_ram (
        .i_clk  (i_clk),
        .i_we   (bs_we),
        .i_re   (bs_re),
        .i_addr (bs_addr),
        .i_wdata(bs_wdata),
        .o_rdata(bs_rdata)
    );

    always_comb begin
        meta_wrow = r_row;
        meta_wrow[r_pick.way].valid = 1'b1;
        meta_wrow[r_pick.way].tag   = cur_tag;
        meta_wrow[r_pick.way].age   = '0;
        meta_wrow[r_pick.way].dirty = (r_op == OP_WRITE) || (r_pick.hit && r_pick.prior_dirty);
    end

    always_comb begin
        line_we    = 1'b0;
        line_re    = 1'b0;
        line_addr  = {r_pick.way, cur_set, r_cnt};
        line_wdata = bs_rdata;
        bs_we      = 1'b0;
        bs_re      = 1'b0;
        bs_addr    = {cur_tag, cur_set, r_cnt};
        bs_wdata   = line_rdata;
        case (r_state)
            S_CLEAR: begin
                bs_we    = 1'b1;
                bs_addr  = r_clr;
                bs_wdata = '0;
            end
            S_WB_RD: begin
                line_re = 1'b1;
            end
            S_WB_WR: begin
                bs_we   = 1'b1;
                bs_addr = {r_pick.old_tag, cur_set, r_cnt};
            end
            S_FL_RD: begin
                bs_re = 1'b1;
            end
            S_FL_WR: begin
                line_we = 1'b1;
            end
            S_ACCESS: begin
                line_addr  = {r_pick.way, cur_set, cur_off};
                line_we    = (r_op == OP_WRITE);
                line_re    = (r_op == OP_READ);
                line_wdata = r_wdata;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == {ADDR_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cnt = '0;
                if (pick.hit) begin
                    n_state = S_ACCESS;
                end else if (pick.old_valid && pick.prior_dirty) begin
                    n_state = S_WB_RD;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_WB_RD: begin
                n_state = S_WB_WR;
            end
            S_WB_WR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == {OFF_BITS{1'b1}}) begin
                    n_state = S_FL_RD;
                end else begin
                    n_state = S_WB_RD;
                end
            end
            S_FL_RD: begin
                n_state = S_FL_WR;
            end
            S_FL_WR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == {OFF_BITS{1'b1}}) begin
                    n_state = S_ACCESS;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_ACCESS: begin
                n_state = (r_op == OP_WRITE) ? S_IDLE : S_RESP;
            end
            S_RESP: begin
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (r_state == S_LOOK) begin
            r_pick <= pick;
            r_row  <= aged;
        end
        if (load_out) begin
            r_odata  <= line_rdata;
            r_ohit   <= r_pick.hit;
            r_odirty <= r_pick.prior_dirty;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_read_data = r_odata;
    assign o_hit       = r_ohit;
    assign o_was_dirty = r_odirty;

    `SWC_ASSERT(a_fill_only_on_miss, (r_state == S_FL_WR) |-> !r_pick.hit, "Refill on a hit.")
    `SWC_ASSERT(a_result_from_resp, $rose(o_valid) |-> $past(r_state == S_RESP) && $past(r_op == OP_READ), "Result not from a read.")
    `SWC_ASSERT(a_way_held, (r_state == S_WB_WR || r_state == S_FL_WR) |-> $stable(r_pick.way), "Chosen way changed during a miss.")
    `SWC_ASSERT_ALWAYS(a_no_accept_in_reset, !i_rst_n |=> !o_ready, "Ready during the store clear.")
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the set-associative write-back cache core.
`timescale 1ns / 1ps
module testbench;
    import swc_pkg::*;

    localparam int NUM_LINES = SETS * WAYS;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] wdata;
    } t_access;

    typedef struct packed {
        logic [DATA_BITS-1:0] rdata;
        logic                 hit;
        logic                 was_dirty;
    } t_read_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_operation;
    logic [ADDR_BITS-1:0] i_address;
    logic [DATA_BITS-1:0] i_write_data;
    logic                 o_valid;
    logic                 i_ready;
    logic [DATA_BITS-1:0] o_read_data;
    logic                 o_hit;
    logic                 o_was_dirty;

    set_assoc_writeback_cache_core i_dut (.*);

    logic                 mdl_valid [NUM_LINES];
    logic [TAG_BITS-1:0]  mdl_tag   [NUM_LINES];
    logic                 mdl_dirty [NUM_LINES];
    logic [AGE_BITS-1:0]  mdl_age   [NUM_LINES];
    logic [DATA_BITS-1:0] mdl_words [NUM_LINES*LINE_WORDS];
    logic [DATA_BITS-1:0] mdl_store [1<<ADDR_BITS];

    t_access      pending_accesses[$];
    t_read_result expected_reads[$];
    int  errors = 0;
    int  hold_off = 0;
    int  gap = 0;
    bit  drain_req = 0;
    int  idle_cycles = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void cache_access(t_access a);
        logic [OFF_BITS-1:0] off;
        logic [SET_BITS-1:0] set;
        logic [TAG_BITS-1:0] tag;
        int first, chosen, base;
        logic [AGE_BITS-1:0] oldest;
        bit hit, prior;
        t_read_result r;
        off = a.addr[OFF_BITS-1:0];
        set = a.addr[OFF_BITS +: SET_BITS];
        tag = a.addr[ADDR_BITS-1 -: TAG_BITS];
        first = set * WAYS;
        chosen = first;
        hit = 0;
        for (int w = 0; w < WAYS; w++)
            if (mdl_age[first+w] != AGE_MAX) mdl_age[first+w] += 1;
        for (int w = 0; w < WAYS; w++)
            if (!hit && mdl_valid[first+w] && mdl_tag[first+w] == tag) begin
                hit = 1;
                chosen = first + w;
            end
        if (!hit) begin
            oldest = mdl_age[first];
            for (int w = 1; w < WAYS; w++)
                if (mdl_age[first+w] > oldest) begin
                    oldest = mdl_age[first+w];
                    chosen = first + w;
                end
        end
        prior = mdl_dirty[chosen];
        if (!hit) begin
            if (mdl_valid[chosen] && mdl_dirty[chosen]) begin
                base = {mdl_tag[chosen], set, {OFF_BITS{1'b0}}};
                for (int k = 0; k < LINE_WORDS; k++)
                    mdl_store[base+k] = mdl_words[chosen*LINE_WORDS+k];
            end
            base = {tag, set, {OFF_BITS{1'b0}}};
            for (int k = 0; k < LINE_WORDS; k++)
                mdl_words[chosen*LINE_WORDS+k] = mdl_store[base+k];
            mdl_tag[chosen] = tag;
            mdl_valid[chosen] = 1;
            mdl_dirty[chosen] = 0;
        end
        mdl_age[chosen] = '0;
        if (a.op == OP_WRITE) begin
            mdl_words[chosen*LINE_WORDS+off] = a.wdata;
            mdl_dirty[chosen] = 1;
        end else begin
            r.rdata = mdl_words[chosen*LINE_WORDS+off];
            r.hit = hit;
            r.was_dirty = prior;
            expected_reads.push_back(r);
        end
    endfunction

    function automatic void push_access(logic op, logic [ADDR_BITS-1:0] addr,
                                        logic [DATA_BITS-1:0] wdata);
        t_access a;
        a.op = op;
        a.addr = addr;
        a.wdata = wdata;
        pending_accesses.push_back(a);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                cache_access({i_operation, i_address, i_write_data});
                void'(pending_accesses.pop_front());
            end
            if (i_valid && !o_ready) begin
            end else if (gap > 0) begin
                i_valid <= 1'b0;
                gap <= gap - 1;
            end else if (drain_req && expected_reads.size() != 0) begin
                i_valid <= 1'b0;
            end else begin
                if (pending_accesses.size() != 0) begin
                    t_access a;
                    a = pending_accesses[0];
                    i_valid <= 1'b1;
                    i_operation <= a.op;
                    i_address <= a.addr;
                    i_write_data <= a.wdata;
                    gap <= rand_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                t_read_result e;
                if (expected_reads.size() == 0) begin
                    $error("unexpected result read_data=%0h", o_read_data);
                    errors++;
                end else begin
                    e = expected_reads.pop_front();
                    if (o_read_data !== e.rdata) begin
                        $error("read_data expected %0h actual %0h", e.rdata, o_read_data);
                        errors++;
                    end
                    if (o_hit !== e.hit) begin
                        $error("hit expected %0b actual %0b", e.hit, o_hit);
                        errors++;
                    end
                    if (o_was_dirty !== e.was_dirty) begin
                        $error("was_dirty expected %0b actual %0b", e.was_dirty, o_was_dirty);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                i_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end else begin
                i_ready <= (rand_gap() == 0) || ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [TAG_BITS-1:0] tags[4];
        for (int l = 0; l < NUM_LINES; l++) begin
            mdl_valid[l] = 0; mdl_tag[l] = '0; mdl_dirty[l] = 0; mdl_age[l] = '0;
        end
        for (int l = 0; l < NUM_LINES*LINE_WORDS; l++) mdl_words[l] = '0;
        for (int k = 0; k < (1<<ADDR_BITS); k++) mdl_store[k] = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operation = OP_READ;
        i_address = '0;
        i_write_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain_req = 1;
        push_access(OP_READ, 16'h0000, 8'h00);
        push_access(OP_WRITE, 16'h0000, 8'hff);
        push_access(OP_READ, 16'h0000, 8'h00);
        push_access(OP_WRITE, 16'hffff, 8'h5a);
        push_access(OP_READ, 16'hffff, 8'h00);
        push_access(OP_READ, 16'hfffc, 8'hff);
        for (int t = 1; t <= 9; t++)
            push_access(t[0] ? OP_WRITE : OP_READ, {t[9:0], 4'h3, 2'd1}, 8'(t * 17));
        push_access(OP_READ, {10'd1, 4'h3, 2'd1}, 8'h00);
        push_access(OP_READ, 16'hffff, 8'h00);
        push_access(OP_READ, 16'h0000, 8'h00);
        push_access(OP_READ, 16'h5555, 8'haa);
        push_access(OP_WRITE, 16'haaaa, 8'h55);
        push_access(OP_READ, 16'haaaa, 8'h00);
        wait (pending_accesses.size() == 0);
        wait (expected_reads.size() == 0);
        repeat (30) @(posedge i_clk);
        drain_req = 0;

        hold_off = 400;
        for (int k = 0; k < 20; k++)
            push_access($urandom_range(0, 1), 16'($urandom), 8'($urandom));

        for (int k = 0; k < 4; k++) tags[k] = 10'($urandom);
        for (int k = 0; k < 480; k++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 60)
                push_access($urandom_range(0, 1),
                            {tags[$urandom_range(0, 3)] + 10'($urandom_range(0, 3)),
                             4'($urandom_range(0, 3)), 2'($urandom)}, 8'($urandom));
            else if (r < 85)
                push_access($urandom_range(0, 1),
                            {10'($urandom_range(0, 11)), 4'h7, 2'($urandom)}, 8'($urandom));
            else
                push_access($urandom_range(0, 1), 16'($urandom), 8'($urandom));
        end
        wait (pending_accesses.size() == 0);
        wait (expected_reads.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/swc_pkg.sv
sv/swc_ram.sv
sv/swc_meta.sv
sv/swc_lru.sv
sv/set_assoc_writeback_cache_core.sv
tb/testbench.sv
